// ===== sv/masked_byte_pattern_scan_assert.svh =====
// Assertion macros shared by the scanner's RTL files.
// Each macro expects signals named clk and rst in the including scope.
`ifndef MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define MBPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbps: assertion failed");

// Next-cycle implication, checked outside of reset.
`define MBPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbps: assertion failed");

`endif

// ===== sv/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scanner.
// Used by the front end, the result queue, the output stage and the top level.
package mbps_pkg;

  // Parameter defaults of the top level.
  localparam int PATTERN_MAX_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed register and field geometry.
  localparam int PAT_REG_BYTES = 32;
  localparam int LEN_W         = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int MASK_W        = 32;
  localparam int OUT_OFFSET_W  = 32;

  // Entries in the queue between the front end and the output stage.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LENGTH     = 3'd0,
    REG_PATTERN_BYTES_LOW  = 3'd1,
    REG_PATTERN_BYTES_MLOW = 3'd2,
    REG_PATTERN_BYTES_MHIGH = 3'd3,
    REG_PATTERN_BYTES_HIGH = 3'd4,
    REG_WILDCARD_MASK      = 3'd5
  } cfg_reg_t;

  // One scan result.
  typedef struct packed {
    logic                    found;
    logic [OUT_OFFSET_W-1:0] offset;
  } result_t;

  // Queue fill status seen by its two neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/mbps_front.sv =====
// Front end of the scanner: configuration registers, byte window and matcher.
// Depends on mbps_pkg and the assertion macro header.
`include "masked_byte_pattern_scan_assert.svh"

module mbps_front import mbps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Byte stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // data_byte
  input  logic                   s_tlast,   // end_of_region
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Result queue write side
  input  q_status_t              q_status,
  output logic                   push,
  output result_t                push_item
);

  localparam int LIM   = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;
  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W = (FILL_W > LEN_W) ? FILL_W : LEN_W;

  // Configuration state.
  logic [LEN_W-1:0]           pattern_length;
  logic [CFG_DATA_W-1:0]      pattern_words [4];
  logic [MASK_W-1:0]          wildcard_mask;

  // Region state.
  logic [7:0]                 window [PATTERN_MAX];
  logic [7:0]                 win_next [PATTERN_MAX];
  logic [OFFSET_BITS-1:0]     byte_position;
  logic                       already_matched;
  logic [FILL_W-1:0]          window_fill;
  logic [FILL_W-1:0]          fill_next;

  logic                       accept;
  logic [LEN_W-1:0]           len;
  logic [8*PAT_REG_BYTES-1:0] pattern_flat;
  logic [LEN_W-1:0]           idx [LIM];
  logic [LIM-1:0]             pos_ok;
  logic                       hit;
  logic [OFFSET_BITS-1:0]     start;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_status.full;
  assign accept    = s_tvalid && s_tready;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      for (int k = 0; k < 4; k++) begin
        pattern_words[k] <= '0;
      end
      wildcard_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH:      pattern_length   <= cfg_data[LEN_W-1:0];
        REG_PATTERN_BYTES_LOW:   pattern_words[0] <= cfg_data;
        REG_PATTERN_BYTES_MLOW:  pattern_words[1] <= cfg_data;
        REG_PATTERN_BYTES_MHIGH: pattern_words[2] <= cfg_data;
        REG_PATTERN_BYTES_HIGH:  pattern_words[3] <= cfg_data;
        REG_WILDCARD_MASK:       wildcard_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Active length: zero counts as one, large values are clamped.
  always_comb begin
    if (pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (pattern_length > LEN_W'(LIM)) begin
      len = LEN_W'(LIM);
    end else begin
      len = pattern_length;
    end
  end

  assign pattern_flat = {pattern_words[3], pattern_words[2], pattern_words[1],
                         pattern_words[0]};

  // Window after the incoming byte is shifted in; entry 0 is the newest.
  always_comb begin
    win_next[0] = s_tdata;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      win_next[j] = window[j-1];
    end
  end

  assign fill_next = (window_fill == FILL_W'(PATTERN_MAX)) ? window_fill
                                                          : window_fill + FILL_W'(1);

  // Pattern position i lines up with the byte that is len-1-i entries old.
  always_comb begin
    for (int i = 0; i < LIM; i++) begin
      idx[i]    = len - LEN_W'(1) - LEN_W'(i);
      pos_ok[i] = 1'b1;
      if (LEN_W'(i) < len && !wildcard_mask[i]) begin
        pos_ok[i] = (pattern_flat[8*i +: 8] == win_next[idx[i][IDX_W-1:0]]);
      end
    end
  end

  assign hit   = (CMP_W'(fill_next) >= CMP_W'(len)) && (&pos_ok);
  assign start = byte_position - OFFSET_BITS'(len - LEN_W'(1));

  // Result toward the queue.
  always_comb begin
    push             = 1'b0;
    push_item.found  = 1'b0;
    push_item.offset = '0;
    if (accept && !already_matched) begin
      if (hit) begin
        push             = 1'b1;
        push_item.found  = 1'b1;
        push_item.offset = OUT_OFFSET_W'(start);
      end else if (s_tlast) begin
        push = 1'b1;
      end
    end
  end

  // Region bookkeeping; the end of a region returns it to its reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      already_matched <= 1'b0;
      window_fill     <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_position   <= '0;
        already_matched <= 1'b0;
        window_fill     <= '0;
      end else begin
        byte_position <= byte_position + OFFSET_BITS'(1);
        if (!already_matched) begin
          window_fill <= fill_next;
          if (hit) begin
            already_matched <= 1'b1;
          end
        end
      end
    end
  end

  // Window bytes older than the fill count are never compared.
  always_ff @(posedge clk) begin
    if (accept && !already_matched) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        window[j] <= win_next[j];
      end
    end
  end

  // Checks on the region logic.
  `MBPS_ASSERT_IMP(a_no_result_after_match, accept && already_matched, !push)
  `MBPS_ASSERT_NXT(a_region_restart, accept && s_tlast,
                   byte_position == '0 && window_fill == '0 && !already_matched)
  `MBPS_ASSERT_IMP(a_found_needs_fill, push && push_item.found,
                   CMP_W'(fill_next) >= CMP_W'(len))

endmodule

// ===== sv/mbps_queue.sv =====
// Short result queue between the scanner front end and its output stage.
// Depends on mbps_pkg and the assertion macro header.
`include "masked_byte_pattern_scan_assert.svh"

module mbps_queue import mbps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  result_t   push_item,
  input  logic      pop,
  output result_t   pop_item,
  output q_status_t q_status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_item       = entries[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Occupancy checks.
  `MBPS_ASSERT_IMP(a_no_push_when_full, push, !q_status.full)
  `MBPS_ASSERT_IMP(a_no_pop_when_empty, pop, !q_status.empty)
  `MBPS_ASSERT_IMP(a_count_bounded, 1'b1, count <= CNT_W'(QUEUE_DEPTH))

endmodule

// ===== sv/mbps_back.sv =====
// Output stage of the scanner: drains the result queue into the result stream.
// Depends on mbps_pkg.
module mbps_back import mbps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  q_status_t               q_status,
  input  result_t                 pop_item,
  output logic                    pop,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_OFFSET_W-1:0] m_tdata,  // match_offset
  output logic                    m_tuser   // found
);

  result_t out_item;

  // Load a new result when the output register is empty or being taken.
  assign pop = !q_status.empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= pop_item;
    end
  end

  assign m_tdata = out_item.offset;
  assign m_tuser = out_item.found;

endmodule

// ===== sv/masked_byte_pattern_scan.sv =====
// Masked byte pattern scanner. Region bytes stream in one per transfer, s_tlast
// marking the last byte of a region. Each accepted byte is shifted into a window
// and compared in parallel against the pattern, wildcard positions matching any
// byte, so one byte is taken every clock cycle; s_tready drops only while the
// two-entry result queue in front of the output register is full. The first
// match of a region yields one transfer with m_tuser = 1 and the start offset in
// m_tdata, by way of the result queue and the output register; the rest of the
// region is consumed silently. A region with no match yields m_tuser = 0 and
// offset 0 on its last byte. The user is to write registers through cfg_* (always
// ready) between regions; the block does not enforce it. No clearing pass runs
// after reset. Depends on mbps_pkg, mbps_front, mbps_queue and mbps_back.
module masked_byte_pattern_scan import mbps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // data_byte
  input  logic                    s_tlast,   // end_of_region
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_OFFSET_W-1:0] m_tdata,   // match_offset
  output logic                    m_tuser,   // found
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  q_status_t q_status;
  logic      push;
  result_t   push_item;
  logic      pop;
  result_t   pop_item;

  // Window, matcher and configuration.
  mbps_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // Result queue.
  mbps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // Output register.
  mbps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop_item (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/sv/masked_byte_pattern_scan_tb.sv =====
// Self-checking testbench for the masked byte pattern scanner.
// Needs only mbps_pkg and the masked_byte_pattern_scan RTL; it runs on its own.
module masked_byte_pattern_scan_tb;
  import mbps_pkg::*;

  localparam int WIN_DEPTH        = PATTERN_MAX_DEF;
  localparam int LEN_CAP          = (PATTERN_MAX_DEF < PAT_REG_BYTES) ? PATTERN_MAX_DEF
                                                                      : PAT_REG_BYTES;
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int SETUPS_PER_PHASE = 4;
  localparam int ITEMS_PER_SETUP  = 75;

  // Register indexes past the end of the register list; writes there are dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW  = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HIGH = 3'd7;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [7:0]              s_tdata = 8'd0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_OFFSET_W-1:0] m_tdata;
  logic                    m_tuser;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  masked_byte_pattern_scan uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the scanner's registers and region state.
  logic [LEN_W-1:0]  len_reg;
  logic [255:0]      pattern_bits;
  logic [MASK_W-1:0] wild_mask;
  logic [7:0]        window_bytes [WIN_DEPTH];
  logic [31:0]       region_pos;
  bit                region_matched;
  int                window_fill;

  result_t expected_scan_results [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int error_count = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic void clear_region();
    for (int j = 0; j < WIN_DEPTH; j++) window_bytes[j] = 8'd0;
    region_pos = '0;
    region_matched = 1'b0;
    window_fill = 0;
  endfunction

  function automatic void reset_mirror();
    len_reg = 6'd1;
    pattern_bits = '0;
    wild_mask = '0;
    clear_region();
  endfunction

  function automatic int active_len();
    int n;
    n = len_reg;
    if (n == 0) n = 1;
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    case (idx)
      REG_PATTERN_LENGTH:      len_reg = value[LEN_W-1:0];
      REG_PATTERN_BYTES_LOW:   pattern_bits[63:0] = value;
      REG_PATTERN_BYTES_MLOW:  pattern_bits[127:64] = value;
      REG_PATTERN_BYTES_MHIGH: pattern_bits[191:128] = value;
      REG_PATTERN_BYTES_HIGH:  pattern_bits[255:192] = value;
      REG_WILDCARD_MASK:       wild_mask = value[MASK_W-1:0];
      default: ;
    endcase
  endfunction

  // Pattern byte 0 lines up with the oldest of the n newest window bytes.
  function automatic bit window_matches(int n);
    for (int i = 0; i < n; i++) begin
      if (!wild_mask[i] && pattern_bits[i*8 +: 8] != window_bytes[n-1-i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Queue one expected result behind those already waiting.
  function automatic void expect_result(logic found, logic [31:0] offset);
    result_t r;
    r.found = found;
    r.offset = offset;
    expected_scan_results = {expected_scan_results, r};
  endfunction

  // Advance the mirror by one accepted byte and queue the result it causes.
  function automatic void scan_byte(logic [7:0] value, logic last);
    int n;
    logic [31:0] start;
    if (!region_matched) begin
      n = active_len();
      for (int j = WIN_DEPTH - 1; j > 0; j--) window_bytes[j] = window_bytes[j-1];
      window_bytes[0] = value;
      if (window_fill < WIN_DEPTH) window_fill++;
      if (window_fill >= n && window_matches(n)) begin
        start = region_pos - 32'(n - 1);
        expect_result(1'b1, start);
        region_matched = 1'b1;
      end else if (last) begin
        expect_result(1'b0, 32'd0);
      end
    end
    if (last) clear_region();
    else region_pos = region_pos + 32'd1;
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_scan_results.size() == 0) begin
        $error("unexpected result: found %0d, match_offset %0d", m_tuser, m_tdata);
        error_count++;
      end else begin
        want = expected_scan_results.pop_front();
        if (m_tuser !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_tuser);
          error_count++;
        end
        if (m_tdata !== want.offset) begin
          $error("match_offset: expected %0d, actual %0d", want.offset, m_tdata);
          error_count++;
        end
      end
    end
  end

  // Stop the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one byte, with random idle cycles in front, and wait for its transfer.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= value;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scan_byte(value, last);
    bytes_sent++;
  endtask

  // Stop sending, wait for every expected result, then let the pipeline empty.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_scan_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, value);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic program_scanner(input logic [63:0] len_word, input logic [255:0] pat,
                                 input logic [63:0] mask_word);
    cfg_write(REG_PATTERN_LENGTH, len_word, 1'b1);
    cfg_write(REG_PATTERN_BYTES_LOW, pat[63:0], 1'b1);
    cfg_write(REG_PATTERN_BYTES_MLOW, pat[127:64], 1'b1);
    cfg_write(REG_PATTERN_BYTES_MHIGH, pat[191:128], 1'b1);
    cfg_write(REG_PATTERN_BYTES_HIGH, pat[255:192], 1'b1);
    cfg_write(REG_WILDCARD_MASK, mask_word, 1'b0);
  endtask

  // Random register setting; a non-negative len_choice fixes the length field.
  task automatic program_random(input int len_choice);
    logic [63:0]  len_word;
    logic [63:0]  mask_word;
    logic [31:0]  mask_bits;
    logic [255:0] pat;
    int r;
    len_word = {$urandom, $urandom};
    r = $urandom_range(99);
    if (len_choice >= 0) len_word[5:0] = 6'(len_choice);
    else if (r < 55) len_word[5:0] = 6'($urandom_range(6, 1));
    else if (r < 80) len_word[5:0] = 6'($urandom_range(16, 7));
    else if (r < 94) len_word[5:0] = 6'($urandom_range(32, 17));
    else len_word[5:0] = ($urandom_range(1) != 0) ? 6'd0 : 6'($urandom_range(63, 33));
    // Sometimes only byte values 0 to 2, so partial and overlapping matches are common.
    r = $urandom_range(99);
    for (int k = 0; k < 32; k++)
      pat[k*8 +: 8] = (r < 35) ? 8'($urandom_range(2)) : 8'($urandom);
    r = $urandom_range(99);
    if (r < 35) mask_bits = '0;
    else if (r < 70) mask_bits = $urandom & $urandom & $urandom;
    else if (r < 90) mask_bits = $urandom;
    else mask_bits = $urandom | $urandom;
    mask_word = {$urandom, mask_bits};
    program_scanner(len_word, pat, mask_word);
  endtask

  function automatic logic [7:0] filler_byte(bit narrow, int n);
    if (narrow) return pattern_bits[$urandom_range(n - 1)*8 +: 8];
    return 8'($urandom);
  endfunction

  // One region, optionally carrying the pattern at plant_at, with one
  // non-wildcard position spoiled when corrupt is set.
  task automatic send_region(input int count, input bit plant, input int plant_at,
                             input bit corrupt, input bit narrow);
    int n;
    int bad;
    int i;
    logic [7:0] b;
    n = active_len();
    bad = -1;
    if (plant && corrupt) begin
      i = $urandom_range(n - 1);
      for (int t = 0; t < n && bad < 0; t++)
        if (!wild_mask[(i + t) % n]) bad = (i + t) % n;
    end
    for (int k = 0; k < count; k++) begin
      if (plant && k >= plant_at && k < plant_at + n) begin
        i = k - plant_at;
        b = wild_mask[i] ? 8'($urandom) : pattern_bits[i*8 +: 8];
        if (i == bad) b = b ^ 8'($urandom_range(255, 1));
      end else begin
        b = filler_byte(narrow, n);
      end
      send_byte(b, k == count - 1);
    end
  endtask

  task automatic random_region();
    int n;
    int kind;
    int count;
    n = active_len();
    kind = $urandom_range(99);
    if (kind < 80) begin
      count = n + $urandom_range(10);
      send_region(count, 1'b1, $urandom_range(count - n), kind >= 65, $urandom_range(1));
    end else if (kind < 90 || n == 1) begin
      send_region($urandom_range(16, 1), 1'b0, 0, 1'b0, $urandom_range(1));
    end else begin
      // Region too short to ever hold the pattern.
      send_region($urandom_range(n - 1, 1), 1'b0, 0, 1'b0, $urandom_range(1));
    end
  endtask

  task automatic test_directed();
    // Reset setting: one byte of value zero.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // Unused register indexes, then a zero length that acts as one.
    cfg_write(REG_SPARE_LOW, {$urandom, $urandom}, 1'b1);
    cfg_write(REG_SPARE_HIGH, {$urandom, $urandom}, 1'b1);
    program_scanner(64'hFFFF_FFFF_FFFF_FFC0, 256'hFF, 64'hFFFF_FFFF_0000_0000);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // Three positions with a wildcard in the middle.
    program_scanner(64'd3, 256'h55_00_AA, 64'h2);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    // Everything after the match, the closing byte too, gives nothing.
    send_byte(8'hAA, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hEE, 1'b1);
    // Match on the closing byte.
    send_byte(8'hAA, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b1);
    drain_results();

    // All positions wildcard.
    program_scanner(64'd2, 256'h0, 64'h3);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain_results();

    // New pattern between bytes of one region; the window is kept.
    program_scanner(64'd2, 256'h44_33, 64'h0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    drain_results();
    cfg_write(REG_PATTERN_BYTES_LOW, 64'h33_22, 1'b0);
    send_byte(8'h33, 1'b1);
    drain_results();
  endtask

  // Hold the receiver off while one-byte regions keep coming, so the
  // result queue fills and the input stalls; then wait for everything.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    program_scanner(64'd1, {8{$urandom}}, 64'hFFFF_FFFF);
    hold_requests++;
    repeat (40) send_byte(8'($urandom), 1'b1);
    drain_results();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int extreme_len);
    int start_count;
    drain_results();
    idle_pct = idle;
    stall_pct = stall;
    for (int s = 0; s < SETUPS_PER_PHASE; s++) begin
      drain_results();
      program_random((s == 0) ? extreme_len : -1);
      start_count = bytes_sent;
      while (bytes_sent - start_count < ITEMS_PER_SETUP) random_region();
    end
  endtask

  initial begin
    reset_mirror();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 0);
    test_random_phase(70, 0, 32);
    test_random_phase(0, 70, 63);
    test_random_phase(36, 36, 33);
    drain_results();
    repeat (16) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_front.sv
sv/mbps_queue.sv
sv/mbps_back.sv
sv/masked_byte_pattern_scan.sv
tb/sv/masked_byte_pattern_scan_tb.sv
